// File: src/hgp_pkg.sv
// ----------------------------------------------------------------------------
// hgp_pkg: shared types and constants of the GET request parser
// Byte codes, keyword tables, parse phase encoding and the result record.
// ----------------------------------------------------------------------------
package hgp_pkg;

    localparam int PATH_LIMIT_DEF = 256;

    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] BYTE_LF    = 8'd10;
    localparam logic [7:0] BYTE_SP    = 8'd32;
    localparam logic [7:0] BYTE_DOT   = 8'h2E;
    localparam logic [7:0] BYTE_SLASH = 8'h2F;

    localparam logic [2:0] MIME_TEXT = 3'd0;
    localparam logic [2:0] MIME_HTML = 3'd1;
    localparam logic [2:0] MIME_JS   = 3'd2;
    localparam logic [2:0] MIME_CSS  = 3'd3;
    localparam logic [2:0] MIME_PNG  = 3'd4;

    localparam logic KIND_PATH    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // End-of-request detector: how much of CR LF CR LF has been seen
    localparam logic [1:0] END_NONE   = 2'd0;
    localparam logic [1:0] END_CR     = 2'd1;
    localparam logic [1:0] END_CRLF   = 2'd2;
    localparam logic [1:0] END_CRLFCR = 2'd3;

    typedef enum logic [4:0] {
        PH_METHOD  = 5'b00001,
        PH_PATH    = 5'b00010,
        PH_VERSION = 5'b00100,
        PH_TAIL    = 5'b01000,
        PH_DONE    = 5'b10000
    } t_phase;

    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [7:0] path_char;
        logic       ok;
        logic [7:0] path_total;
        logic [2:0] mime_class;
        logic       last;
    } t_result;

    function automatic logic [7:0] method_char(input logic [1:0] pos);
        logic [7:0] c;
        unique case (pos)
            2'd0:    c = 8'h47; // G
            2'd1:    c = 8'h45; // E
            2'd2:    c = 8'h54; // T
            default: c = BYTE_SP;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] version_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h48; // H
            3'd1:    c = 8'h54; // T
            3'd2:    c = 8'h54; // T
            3'd3:    c = 8'h50; // P
            3'd4:    c = 8'h2F; // /
            3'd5:    c = 8'h31; // 1
            3'd6:    c = 8'h2E; // .
            default: c = 8'h31; // 1
        endcase
        return c;
    endfunction

    // Candidate extensions in priority order: .html .js .css .png
    function automatic logic [2:0] ext_size(input logic [1:0] idx);
        logic [2:0] s;
        unique case (idx)
            2'd0:    s = 3'd5;
            2'd1:    s = 3'd3;
            default: s = 3'd4;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] ext_char(input logic [1:0] idx, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        unique case (idx)
            2'd0: begin
                unique case (pos)
                    3'd0:    c = BYTE_DOT;
                    3'd1:    c = 8'h68; // h
                    3'd2:    c = 8'h74; // t
                    3'd3:    c = 8'h6D; // m
                    3'd4:    c = 8'h6C; // l
                    default: c = 8'h00;
                endcase
            end
            2'd1: begin
                unique case (pos)
                    3'd0:    c = BYTE_DOT;
                    3'd1:    c = 8'h6A; // j
                    3'd2:    c = 8'h73; // s
                    default: c = 8'h00;
                endcase
            end
            2'd2: begin
                unique case (pos)
                    3'd0:    c = BYTE_DOT;
                    3'd1:    c = 8'h63; // c
                    3'd2:    c = 8'h73; // s
                    3'd3:    c = 8'h73; // s
                    default: c = 8'h00;
                endcase
            end
            default: begin
                unique case (pos)
                    3'd0:    c = BYTE_DOT;
                    3'd1:    c = 8'h70; // p
                    3'd2:    c = 8'h6E; // n
                    3'd3:    c = 8'h67; // g
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

// File: src/hgp_in_stage.sv
// ----------------------------------------------------------------------------
// hgp_in_stage: input byte register
// Holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module hgp_in_stage
    import hgp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

endmodule

// File: src/hgp_parser.sv
// ----------------------------------------------------------------------------
// hgp_parser: request-line parse state and per-byte step logic
// Updates the parse state for one byte and forms the result it causes.
// ----------------------------------------------------------------------------
module hgp_parser
    import hgp_pkg::*;
#(
    parameter int PATH_LIMIT = PATH_LIMIT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output t_result    o_result
);

    localparam int CNT_W = $clog2(PATH_LIMIT);
    localparam int LEN_W = (CNT_W > 8) ? CNT_W : 8;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(PATH_LIMIT - 1);

    t_phase           r_phase, n_phase;
    logic [2:0]       r_mpos, n_mpos;
    logic [1:0]       r_end, n_end;
    logic             r_cr, n_cr;
    logic             r_bad, n_bad;
    logic [CNT_W-1:0] r_count, n_count;
    logic [3:0]       r_match, n_match;
    logic [2:0]       r_elen, n_elen;
    logic             r_epres, n_epres;

    logic             req_end;
    logic             emit;
    logic [2:0]       mime;
    logic [LEN_W-1:0] count_ext;

    always_comb begin
        n_phase = r_phase;
        n_mpos  = r_mpos;
        n_end   = r_end;
        n_bad   = r_bad;
        n_count = r_count;
        n_match = r_match;
        n_elen  = r_elen;
        n_epres = r_epres;
        req_end = 1'b0;
        emit    = 1'b0;

        // request end detector
        if (i_byte == BYTE_CR) begin
            n_end = (r_end == END_CRLF) ? END_CRLFCR : END_CR;
        end else if (i_byte == BYTE_LF) begin
            if (r_end == END_CR) begin
                n_end = END_CRLF;
            end else if (r_end == END_CRLFCR) begin
                req_end = 1'b1;
            end else begin
                n_end = END_NONE;
            end
        end else begin
            n_end = END_NONE;
        end

        if (r_phase != PH_DONE) begin
            if (i_byte == BYTE_LF && r_cr) begin
                if (r_phase != PH_TAIL) begin
                    n_bad = 1'b1;
                end
                n_phase = PH_DONE;
            end else begin
                unique case (r_phase)
                    PH_METHOD: begin
                        if (i_byte != method_char(r_mpos[1:0])) begin
                            n_bad   = 1'b1;
                            n_phase = PH_TAIL;
                        end else if (r_mpos >= 3'd3) begin
                            n_phase = PH_PATH;
                            n_mpos  = 3'd0;
                        end else begin
                            n_mpos = r_mpos + 3'd1;
                        end
                    end
                    PH_PATH: begin
                        if (i_byte == BYTE_SP) begin
                            n_phase = PH_VERSION;
                            n_mpos  = 3'd0;
                        end else begin
                            n_mpos = 3'd1;
                            // drop one leading slash
                            if (!(r_mpos == 3'd0 && i_byte == BYTE_SLASH)) begin
                                if (r_count < CNT_MAX) begin
                                    n_count = r_count + CNT_W'(1);
                                    emit    = 1'b1;
                                    if (i_byte == BYTE_DOT) begin
                                        n_epres = 1'b1;
                                        n_match = 4'hF;
                                        n_elen  = 3'd1;
                                    end else if (r_epres) begin
                                        for (int i = 0; i < 4; i++) begin
                                            if (!(r_elen < ext_size(2'(i)) &&
                                                  ext_char(2'(i), r_elen) == i_byte)) begin
                                                n_match[i] = 1'b0;
                                            end
                                        end
                                        if (r_elen < 3'd7) begin
                                            n_elen = r_elen + 3'd1;
                                        end
                                    end
                                end else begin
                                    n_bad = 1'b1;
                                end
                            end
                        end
                    end
                    PH_VERSION: begin
                        if (i_byte != version_char(r_mpos)) begin
                            n_bad   = 1'b1;
                            n_phase = PH_TAIL;
                        end else if (r_mpos >= 3'd7) begin
                            n_phase = PH_TAIL;
                        end else begin
                            n_mpos = r_mpos + 3'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        n_cr = (i_byte == BYTE_CR);
    end

    // mime class from the last extension, first surviving candidate wins
    always_comb begin
        mime = MIME_TEXT;
        if (n_epres) begin
            priority if (n_match[0]) mime = MIME_HTML;
            else if (n_match[1])     mime = MIME_JS;
            else if (n_match[2])     mime = MIME_CSS;
            else if (n_match[3])     mime = MIME_PNG;
            else                     mime = MIME_TEXT;
        end
    end

    assign count_ext = LEN_W'(n_count);

    always_comb begin
        o_result            = '0;
        o_result.valid      = req_end || emit;
        if (req_end) begin
            o_result.kind       = KIND_VERDICT;
            o_result.ok         = !n_bad;
            o_result.path_total = (count_ext > LEN_W'(255)) ? 8'hFF : count_ext[7:0];
            o_result.mime_class = n_bad ? MIME_TEXT : mime;
            o_result.last       = 1'b1;
        end else begin
            o_result.kind      = KIND_PATH;
            o_result.path_char = emit ? i_byte : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && req_end)) begin
            r_phase <= PH_METHOD;
            r_mpos  <= '0;
            r_end   <= END_NONE;
            r_cr    <= 1'b0;
            r_bad   <= 1'b0;
            r_count <= '0;
            r_match <= '0;
            r_elen  <= '0;
            r_epres <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_mpos  <= n_mpos;
            r_end   <= n_end;
            r_cr    <= n_cr;
            r_bad   <= n_bad;
            r_count <= n_count;
            r_match <= n_match;
            r_elen  <= n_elen;
            r_epres <= n_epres;
        end
    end

endmodule

// File: src/http_get_request_parser.sv
// A byte accepted into the input byte register passes the parser step logic, and any
// result it gives goes to the result register, once that register is free to load.
// Throughput: one byte per cycle while the result side takes each beat. The single
// pass through the parser step logic between the input byte register and the result
// register sets that figure.
// Reset (synchronous, active low) returns the parser to the method phase and empties both.
// ----------------------------------------------------------------------------
// http_get_request_parser: streaming HTTP GET request-line parser
// Takes one request byte per beat, emits path bytes (leading slash dropped)
// and an end-of-request verdict with status, path length and mime class.
// ----------------------------------------------------------------------------
module http_get_request_parser
    import hgp_pkg::*;
#(
    parameter int PATH_LIMIT = PATH_LIMIT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte channel
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    // result channel
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic       o_kind,
    output logic [7:0] o_path_char,
    output logic       o_ok,
    output logic [7:0] o_path_total,
    output logic [2:0] o_mime_class,
    output logic       o_last
);

    logic       stage_valid;
    logic [7:0] stage_byte;
    logic       out_free;
    logic       advance;
    t_result    step_result;

    logic       r_out_valid;
    t_result    r_out;

    // The result register is free when empty or when its beat leaves this
    // cycle; a staged byte advances only then, whether or not it gives a result.
    assign out_free = !r_out_valid || i_res_ready;
    assign advance  = stage_valid && out_free;

    // Input byte register: takes a new beat while the parser consumes the last one
    hgp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx_valid),
        .o_ready (o_rx_ready),
        .i_byte  (i_rx_byte),
        .i_take  (advance),
        .o_valid (stage_valid),
        .o_byte  (stage_byte)
    );

    // Parse state and step logic: commit the state only when the byte advances
    hgp_parser #(
        .PATH_LIMIT (PATH_LIMIT)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (stage_byte),
        .o_result (step_result)
    );

    // Result register: hold a beat until taken, load the next one behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && step_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_result.valid) begin
            r_out <= step_result;
        end
    end

    assign o_res_valid  = r_out_valid;
    assign o_kind       = r_out.kind;
    assign o_path_char  = r_out.path_char;
    assign o_ok         = r_out.ok;
    assign o_path_total = r_out.path_total;
    assign o_mime_class = r_out.mime_class;
    assign o_last       = r_out.last;

endmodule

// File: bench/http_get_request_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_get_request_parser_tb: self-checking bench for the GET request parser
// Streams request bytes through the valid/ready byte channel and checks every
// result beat against a cycle-free model of the parser kept in the bench: a
// short table of hand-picked bytes first, then randomised requests, mostly
// well formed, with mutated, truncated and noise requests mixed in.
// ----------------------------------------------------------------------------
module http_get_request_parser_tb;
    import hgp_pkg::*;

    localparam int PATH_LIMIT      = PATH_LIMIT_DEF;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DIRECTED_COUNT  = 24;

    // Keyword text, left-justified so that byte n sits at bits [8*(width-1-n) +: 8]
    localparam logic [31:0] METHOD_TEXT  = "GET ";
    localparam logic [63:0] VERSION_TEXT = "HTTP/1.1";
    localparam logic [39:0] EXT_TEXT [4] = '{".html", {".js", 16'h0}, {".css", 8'h0},
                                             {".png", 8'h0}};
    localparam int          EXT_SIZE [4] = '{5, 3, 4, 4};
    localparam logic [2:0]  EXT_MIME [4] = '{MIME_HTML, MIME_JS, MIME_CSS, MIME_PNG};

    typedef struct packed {
        logic       kind;
        logic [7:0] path_char;
        logic       ok;
        logic [7:0] path_total;
        logic [2:0] mime_class;
        logic       last;
    } parse_beat_t;

    typedef struct packed {
        logic [7:0]  rx;
        logic        typed;
        parse_beat_t beat;
    } stim_row_t;

    localparam parse_beat_t NO_BEAT = '0;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports
    // ------------------------------------------------------------------------
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_rx_valid  = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_res_ready = 1'b0;
    logic       o_rx_ready;
    logic       o_res_valid;
    logic       o_kind;
    logic [7:0] o_path_char;
    logic       o_ok;
    logic [7:0] o_path_total;
    logic [2:0] o_mime_class;
    logic       o_last;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    http_get_request_parser #(
        .PATH_LIMIT(PATH_LIMIT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_kind      (o_kind),
        .o_path_char (o_path_char),
        .o_ok        (o_ok),
        .o_path_total(o_path_total),
        .o_mime_class(o_mime_class),
        .o_last      (o_last)
    );

    // ------------------------------------------------------------------------
    // Bench-side parser state, mirrored one accepted byte at a time
    // ------------------------------------------------------------------------
    t_phase     rl_phase;
    logic [3:0] rl_pos;        // place in "GET " or "HTTP/1.1"; in the path, 1 once started
    logic [1:0] crlf_state;    // progress through CR LF CR LF
    logic       last_was_cr;
    logic       line_closed;
    logic       req_bad;
    logic [8:0] path_bytes;
    logic [3:0] ext_live;      // candidate extensions still matching
    logic [2:0] ext_seen;      // extension bytes so far, dot included, saturating
    logic       ext_dot_seen;

    parse_beat_t awaited_beats [$];

    // Run statistics and traffic shaping
    int bytes_sent     = 0;
    int requests_sent  = 0;
    int path_beats     = 0;
    int verdicts       = 0;
    int ok_verdicts    = 0;
    int mismatch_count = 0;
    int sender_idle_pct = 23;
    int recv_idle_pct   = 45;
    int taken      = 0;
    int stall_left = 0;

    logic [7:0] req_bytes [$];

    function automatic void clear_request_state();
        rl_phase     = PH_METHOD;
        rl_pos       = '0;
        crlf_state   = END_NONE;
        last_was_cr  = 1'b0;
        line_closed  = 1'b0;
        req_bad      = 1'b0;
        path_bytes   = '0;
        ext_live     = '0;
        ext_seen     = '0;
        ext_dot_seen = 1'b0;
    endfunction

    // Follow the extension from the last dot: each byte knocks out candidates
    function automatic void follow_extension(input logic [7:0] b);
        if (b == BYTE_DOT) begin
            ext_dot_seen = 1'b1;
            ext_live     = 4'hF;
            ext_seen     = 3'd1;
        end else if (ext_dot_seen) begin
            for (int i = 0; i < 4; i++) begin
                logic keep;
                keep = 1'b0;
                if (ext_seen < EXT_SIZE[i])
                    keep = (EXT_TEXT[i][8 * (4 - ext_seen) +: 8] == b);
                if (!keep)
                    ext_live[i] = 1'b0;
            end
            if (ext_seen < 3'd7)
                ext_seen = ext_seen + 3'd1;
        end
    endfunction

    function automatic logic [2:0] mime_from_extension();
        if (ext_dot_seen) begin
            for (int i = 0; i < 4; i++)
                if (ext_live[i])
                    return EXT_MIME[i];
        end
        return MIME_TEXT;
    endfunction

    // Advance the mirrored parser by one byte; report the beat it produces, if any
    function automatic void parse_request_byte(input logic [7:0] b, output logic produced,
                                               output parse_beat_t beat);
        logic req_end;
        logic emit;
        req_end  = 1'b0;
        emit     = 1'b0;
        produced = 1'b0;
        beat     = NO_BEAT;

        if (b == BYTE_CR) begin
            crlf_state = (crlf_state == END_CRLF) ? END_CRLFCR : END_CR;
        end else if (b == BYTE_LF) begin
            if (crlf_state == END_CR)
                crlf_state = END_CRLF;
            else if (crlf_state == END_CRLFCR)
                req_end = 1'b1;
            else
                crlf_state = END_NONE;
        end else begin
            crlf_state = END_NONE;
        end

        if (!line_closed) begin
            if (b == BYTE_LF && last_was_cr) begin
                // the first line closes here; anything short of the tail is bad
                if (rl_phase != PH_TAIL)
                    req_bad = 1'b1;
                line_closed = 1'b1;
                rl_phase    = PH_DONE;
            end else begin
                case (rl_phase)
                    PH_METHOD: begin
                        if (b != METHOD_TEXT[8 * (3 - rl_pos[1:0]) +: 8]) begin
                            req_bad  = 1'b1;
                            rl_phase = PH_TAIL;
                        end else if (rl_pos >= 4'd3) begin
                            rl_phase = PH_PATH;
                            rl_pos   = '0;
                        end else begin
                            rl_pos = rl_pos + 4'd1;
                        end
                    end
                    PH_PATH: begin
                        if (b == BYTE_SP) begin
                            rl_phase = PH_VERSION;
                            rl_pos   = '0;
                        end else begin
                            logic skip;
                            skip   = (rl_pos == 4'd0 && b == BYTE_SLASH);
                            rl_pos = 4'd1;
                            if (!skip) begin
                                if (path_bytes < PATH_LIMIT - 1) begin
                                    path_bytes = path_bytes + 9'd1;
                                    follow_extension(b);
                                    emit = 1'b1;
                                end else begin
                                    req_bad = 1'b1;
                                end
                            end
                        end
                    end
                    PH_VERSION: begin
                        if (b != VERSION_TEXT[8 * (7 - rl_pos[2:0]) +: 8]) begin
                            req_bad  = 1'b1;
                            rl_phase = PH_TAIL;
                        end else if (rl_pos >= 4'd7) begin
                            rl_phase = PH_TAIL;
                        end else begin
                            rl_pos = rl_pos + 4'd1;
                        end
                    end
                    default: ;
                endcase
            end
        end
        last_was_cr = (b == BYTE_CR);

        if (req_end) begin
            produced        = 1'b1;
            beat.kind       = KIND_VERDICT;
            beat.ok         = !req_bad;
            beat.path_total = (path_bytes > 9'd255) ? 8'd255 : path_bytes[7:0];
            beat.mime_class = req_bad ? MIME_TEXT : mime_from_extension();
            beat.last       = 1'b1;
            clear_request_state();
        end else if (emit) begin
            produced       = 1'b1;
            beat.kind      = KIND_PATH;
            beat.path_char = b;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Directed table: bare ends after odd first bytes, a CR inside the path
    // and a line that ends before the version. Only hand-typed beats are listed.
    // ------------------------------------------------------------------------
    stim_row_t directed_rows [DIRECTED_COUNT] = '{
        // all-ones byte breaks the method at once
        '{8'hFF,    1'b0, NO_BEAT},
        '{BYTE_CR,  1'b0, NO_BEAT},
        '{BYTE_LF,  1'b0, NO_BEAT},
        '{BYTE_CR,  1'b0, NO_BEAT},
        '{BYTE_LF,  1'b1, '{KIND_VERDICT, 8'h00, 1'b0, 8'd0, MIME_TEXT, 1'b1}},
        // zero byte is just another wrong method byte
        '{8'h00,    1'b0, NO_BEAT},
        '{BYTE_CR,  1'b0, NO_BEAT},
        '{BYTE_LF,  1'b0, NO_BEAT},
        '{BYTE_CR,  1'b0, NO_BEAT},
        '{BYTE_LF,  1'b1, '{KIND_VERDICT, 8'h00, 1'b0, 8'd0, MIME_TEXT, 1'b1}},
        // "GET ." then CR: the CR is still a path byte, the line ends early
        '{"G",      1'b0, NO_BEAT},
        '{"E",      1'b0, NO_BEAT},
        '{"T",      1'b0, NO_BEAT},
        '{BYTE_SP,  1'b0, NO_BEAT},
        '{BYTE_DOT, 1'b1, '{KIND_PATH, BYTE_DOT, 1'b0, 8'd0, MIME_TEXT, 1'b0}},
        '{BYTE_CR,  1'b1, '{KIND_PATH, BYTE_CR, 1'b0, 8'd0, MIME_TEXT, 1'b0}},
        '{BYTE_LF,  1'b0, NO_BEAT},
        '{BYTE_CR,  1'b0, NO_BEAT},
        '{BYTE_LF,  1'b1, '{KIND_VERDICT, 8'h00, 1'b0, 8'd2, MIME_TEXT, 1'b1}},
        // lone LF first: no CR before it, so it only spoils the method
        '{BYTE_LF,  1'b0, NO_BEAT},
        '{BYTE_CR,  1'b0, NO_BEAT},
        '{BYTE_LF,  1'b0, NO_BEAT},
        '{BYTE_CR,  1'b0, NO_BEAT},
        '{BYTE_LF,  1'b1, '{KIND_VERDICT, 8'h00, 1'b0, 8'd0, MIME_TEXT, 1'b1}}
    };

    string ext_pool [12] = '{".html", ".htm", ".h", ".js", ".j", ".css", ".cs", ".png",
                             ".pn", ".", ".txt", ".jsx"};

    // ------------------------------------------------------------------------
    // Sender: offer one byte, hold it until taken, then update the model.
    // Valid is only dropped inside an idle gap, so a back-to-back beat never
    // sees valid lowered and raised in the same step.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic typed, input parse_beat_t hand_beat);
        logic        produced;
        parse_beat_t beat;
        // idle mix follows progress through the stream
        if (bytes_sent < 500) begin
            sender_idle_pct = 23;
            recv_idle_pct   = 45;
        end else if (bytes_sent < 1000) begin
            sender_idle_pct = 45;
            recv_idle_pct   = 23;
        end else begin
            sender_idle_pct = 0;
            recv_idle_pct   = 0;
        end
        while ($urandom_range(99) < sender_idle_pct) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do
            @(posedge i_clk);
        while (!o_rx_ready);
        bytes_sent++;
        parse_request_byte(b, produced, beat);
        // a hand-typed row stands in for the modelled beat
        if (typed) begin
            produced = 1'b1;
            beat     = hand_beat;
        end
        if (produced)
            awaited_beats.push_back(beat);
    endtask

    task automatic append_text(input string s);
        for (int i = 0; i < s.len(); i++)
            req_bytes.push_back(s[i]);
    endtask

    task automatic append_crlf();
        req_bytes.push_back(BYTE_CR);
        req_bytes.push_back(BYTE_LF);
    endtask

    function automatic logic [7:0] random_path_char();
        string      alphabet;
        logic [7:0] c;
        alphabet = "abcdefghijklmnopXYZ0123456789/._-~";
        if ($urandom_range(15) == 0) begin
            // any byte but the space that would close the path
            c = 8'($urandom_range(255));
            if (c == BYTE_SP)
                c = 8'h7E;
            return c;
        end
        return alphabet[$urandom_range(alphabet.len() - 1)];
    endfunction

    // Build one request: 70% clean, 10% with a mutated byte, 10% with a cut
    // version, 10% raw noise. Every kind ends with the blank line.
    task automatic build_request();
        int    flavour;
        int    path_size;
        string version;
        req_bytes.delete();
        flavour = $urandom_range(99);
        if (flavour >= 90) begin
            repeat ($urandom_range(1, 20))
                req_bytes.push_back(8'($urandom_range(255)));
            append_crlf();
        end else begin
            append_text("GET ");
            if ($urandom_range(4) != 0)
                req_bytes.push_back(BYTE_SLASH);
            // now and then a path that runs into the length limit
            path_size = ($urandom_range(39) == 0) ? $urandom_range(250, 262)
                                                  : $urandom_range(0, 10);
            repeat (path_size)
                req_bytes.push_back(random_path_char());
            if ($urandom_range(2) != 0)
                append_text(ext_pool[$urandom_range(11)]);
            version = " HTTP/1.1";
            if (flavour >= 80)
                version = version.substr(0, $urandom_range(7));
            append_text(version);
            if ($urandom_range(3) == 0)
                append_text(" keep");
            append_crlf();
            if ($urandom_range(1) == 1) begin
                append_text("Host: h");
                append_crlf();
            end
            if (flavour >= 70 && flavour < 80)
                req_bytes[$urandom_range(req_bytes.size() - 1)] = 8'($urandom_range(255));
        end
        append_crlf();
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure, plus two long hold-offs while the sender
    // keeps offering, so the parser fills and stalls its byte input.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_res_ready <= 1'b0;
        end else if (o_res_valid && i_res_ready && (taken == 150 || taken == 700)) begin
            stall_left  <= HOLD_OFF_CYCLES;
            i_res_ready <= 1'b0;
        end else begin
            i_res_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
        if (o_res_valid && i_res_ready)
            taken <= taken + 1;
    end

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatch_count++;
        $display("mismatch at %0t: %s got %0d, want %0d", $realtime, field, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Checker: each taken result beat against the oldest awaited beat
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        parse_beat_t want;
        parse_beat_t got;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            got = '{o_kind, o_path_char, o_ok, o_path_total, o_mime_class, o_last};
            if (awaited_beats.size() == 0) begin
                report_mismatch("unexpected beat, kind", got.kind, -1);
            end else begin
                want = awaited_beats.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch("kind", got.kind, want.kind);
                if (got.path_char !== want.path_char)
                    report_mismatch("path_char", got.path_char, want.path_char);
                if (got.ok !== want.ok)
                    report_mismatch("ok", got.ok, want.ok);
                if (got.path_total !== want.path_total)
                    report_mismatch("path_total", got.path_total, want.path_total);
                if (got.mime_class !== want.mime_class)
                    report_mismatch("mime_class", got.mime_class, want.mime_class);
                if (got.last !== want.last)
                    report_mismatch("last", got.last, want.last);
                if (want.kind == KIND_VERDICT) begin
                    verdicts++;
                    if (want.ok)
                        ok_verdicts++;
                end else begin
                    path_beats++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        clear_request_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r])
            send_byte(directed_rows[r].rx, directed_rows[r].typed, directed_rows[r].beat);

        // keep going until both the byte count and the request count are met
        while (bytes_sent < 1200 || requests_sent < 48) begin
            build_request();
            foreach (req_bytes[k])
                send_byte(req_bytes[k], 1'b0, NO_BEAT);
            requests_sent++;
        end
        i_rx_valid <= 1'b0;

        // drain, then keep the clock running so that strays can show up
        while (awaited_beats.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);

        $display("run covered %0d bytes in %0d random requests after the directed table",
                 bytes_sent, requests_sent);
        $display("checked %0d path beats and %0d verdicts, %0d of them ok",
                 path_beats, verdicts, ok_verdicts);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest legal run with both hold-offs
    initial begin
        #1000000;
        $display("timeout with %0d beats still awaited", awaited_beats.size());
        $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
src/hgp_pkg.sv
src/hgp_in_stage.sv
src/hgp_parser.sv
src/http_get_request_parser.sv
bench/http_get_request_parser_tb.sv
